[rtl/jsonp_pkg.sv]
// Shared types, phase codes and byte helpers for the flat JSON object parser.
package jsonp_pkg;

    localparam logic [3:0] PH_OPEN       = 4'd0;
    localparam logic [3:0] PH_AFTER_OPEN = 4'd1;
    localparam logic [3:0] PH_STR        = 4'd2;
    localparam logic [3:0] PH_ESC        = 4'd3;
    localparam logic [3:0] PH_HEX        = 4'd4;
    localparam logic [3:0] PH_AFTER_KEY  = 4'd5;
    localparam logic [3:0] PH_BEFORE_VAL = 4'd6;
    localparam logic [3:0] PH_AFTER_VAL  = 4'd7;
    localparam logic [3:0] PH_EXPECT_KEY = 4'd8;
    localparam logic [3:0] PH_DONE       = 4'd9;

    localparam logic [1:0] PART_NONE  = 2'd0;
    localparam logic [1:0] PART_KEY   = 2'd1;
    localparam logic [1:0] PART_VALUE = 2'd2;

    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [7:0]  UTF8_MASK    = 8'h3F;
    localparam logic [15:0] UTF8_TWO_MAX = 16'h0800;
    localparam logic [15:0] UTF8_ONE_MAX = 16'h0080;

    typedef struct packed {
        logic [3:0]  phase;
        logic        in_value;
        logic [15:0] code_point;
        logic [1:0]  hex_seen;
        logic        pair_open;
    } t_state;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] part;
        logic       commit;
        logic       stop;
        logic       dropped;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[rtl/jsonp_step.sv]
// Next-state and result logic for one byte of JSON text.
module jsonp_step (
    input  jsonp_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output jsonp_pkg::t_state  o_state,
    output jsonp_pkg::t_result o_result
);
    import jsonp_pkg::*;

    always_comb begin
        t_state      s;
        t_result     r;
        logic [4:0]  hv;
        logic [15:0] cp;
        logic        stopped;

        s       = i_state;
        r       = '0;
        hv      = hex_val(i_byte);
        cp      = {i_state.code_point[11:0], hv[3:0]};
        stopped = 1'b0;

        unique case (i_state.phase)
            PH_OPEN: begin
                if (!is_ws(i_byte)) begin
                    if (i_byte == "{") s.phase = PH_AFTER_OPEN;
                    else               r.stop  = 1'b1;
                end
            end
            PH_AFTER_OPEN, PH_EXPECT_KEY: begin
                if (!is_ws(i_byte)) begin
                    if (i_byte == "\"") begin
                        s.phase     = PH_STR;
                        s.in_value  = 1'b0;
                        s.pair_open = 1'b1;
                    end else begin
                        r.stop = 1'b1;
                    end
                end
            end
            PH_STR: begin
                if (i_byte == "\"") begin
                    if (i_state.in_value) begin
                        r.commit    = 1'b1;
                        s.pair_open = 1'b0;
                        s.phase     = PH_AFTER_VAL;
                    end else begin
                        s.phase = PH_AFTER_KEY;
                    end
                end else if (i_byte == "\\") begin
                    s.phase = PH_ESC;
                end else begin
                    r.count = 2'd1;
                    r.byte0 = i_byte;
                end
            end
            PH_ESC: begin
                s.phase = PH_STR;
                r.count = 2'd1;
                unique case (i_byte)
                    "\"":    r.byte0 = 8'h22;
                    "\\":    r.byte0 = 8'h5C;
                    "/":     r.byte0 = 8'h2F;
                    "b":     r.byte0 = 8'h08;
                    "f":     r.byte0 = 8'h0C;
                    "n":     r.byte0 = 8'h0A;
                    "r":     r.byte0 = 8'h0D;
                    "t":     r.byte0 = 8'h09;
                    "u": begin
                        r.count      = 2'd0;
                        s.phase      = PH_HEX;
                        s.code_point = '0;
                        s.hex_seen   = '0;
                    end
                    default: begin
                        r.count = 2'd0;
                        r.stop  = 1'b1;
                    end
                endcase
            end
            PH_HEX: begin
                if (!hv[4]) begin
                    r.stop = 1'b1;
                end else if (i_state.hex_seen != 2'd3) begin
                    s.code_point = cp;
                    s.hex_seen   = i_state.hex_seen + 2'd1;
                end else begin
                    // Fourth digit: encode the code point as UTF-8.
                    if (cp < UTF8_ONE_MAX) begin
                        r.count = 2'd1;
                        r.byte0 = cp[7:0];
                    end else if (cp < UTF8_TWO_MAX) begin
                        r.count = 2'd2;
                        r.byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
                        r.byte1 = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
                    end else begin
                        r.count = 2'd3;
                        r.byte0 = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                        r.byte1 = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
                        r.byte2 = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
                    end
                    s.code_point = '0;
                    s.hex_seen   = '0;
                    s.phase      = PH_STR;
                end
            end
            PH_AFTER_KEY: begin
                if (!is_ws(i_byte)) begin
                    if (i_byte == ":") s.phase = PH_BEFORE_VAL;
                    else               r.stop  = 1'b1;
                end
            end
            PH_BEFORE_VAL: begin
                if (!is_ws(i_byte)) begin
                    if (i_byte == "\"") begin
                        s.phase    = PH_STR;
                        s.in_value = 1'b1;
                    end else begin
                        r.stop = 1'b1;
                    end
                end
            end
            PH_AFTER_VAL: begin
                if (!is_ws(i_byte)) begin
                    if (i_byte == ",") s.phase = PH_EXPECT_KEY;
                    else               r.stop  = 1'b1;
                end
            end
            default: begin
                // Stopped: swallow bytes until the last one of this text.
                stopped = 1'b1;
                if (i_last) s.phase = PH_OPEN;
            end
        endcase

        if (!stopped) begin
            r.part = (r.count == 2'd0) ? PART_NONE
                   : (s.in_value ? PART_VALUE : PART_KEY);
            if (i_last) r.stop = 1'b1;
            if (r.stop) begin
                r.dropped    = s.pair_open;
                s.pair_open  = 1'b0;
                s.in_value   = 1'b0;
                s.code_point = '0;
                s.hex_seen   = '0;
                s.phase      = i_last ? PH_OPEN : PH_DONE;
            end
        end

        o_state  = s;
        o_result = r;
    end

endmodule

[rtl/json_flat_object_string_parser_core.sv]
// Top level of the flat JSON object parser: handshakes, input and result registers.
//
// Input channel: i_valid / o_ready carry one byte of JSON text per beat
// (i_in_byte), with i_in_last set on the final byte of a text.
// Output channel: o_valid / i_ready carry exactly one result beat per input
// beat: up to three decoded string bytes (o_out_count, o_out_byte0..2),
// whether they belong to a key or a value (o_out_part), and the flags
// o_pair_commit, o_parse_end and o_pair_dropped.
// Path: an accepted beat sits in the input register, is decoded there and
// lands in the result register when the output side can take it.
// Throughput: one byte per cycle while results are taken; the parser state is
// a single register updated by short logic as the byte moves into the result
// register. When the receiver stalls, the result register holds and the input
// register takes one more beat only if empty; further beats wait for the result.
// Reset clears both registers' valid flags and returns the parser to
// expecting an opening brace.
module json_flat_object_string_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_count,
    output logic [7:0] o_out_byte0,
    output logic [7:0] o_out_byte1,
    output logic [7:0] o_out_byte2,
    output logic [1:0] o_out_part,
    output logic       o_pair_commit,
    output logic       o_parse_end,
    output logic       o_pair_dropped
);
    import jsonp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_state     r_state;
    t_state     n_state;
    t_result    n_res;
    logic       adv;

    jsonp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_OPEN, default: '0};
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (adv) r_res <= n_res;
    end

    assign o_valid        = r_out_valid;
    assign o_out_count    = r_res.count;
    assign o_out_byte0    = r_res.byte0;
    assign o_out_byte1    = r_res.byte1;
    assign o_out_byte2    = r_res.byte2;
    assign o_out_part     = r_res.part;
    assign o_pair_commit  = r_res.commit;
    assign o_parse_end    = r_res.stop;
    assign o_pair_dropped = r_res.dropped;

endmodule

[bench/json_flat_object_string_parser_checker.sv]
// Result checker for the flat JSON object parser: predicts every result beat and compares it.
module json_flat_object_string_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_out_count,
    input  logic [7:0] i_out_byte0,
    input  logic [7:0] i_out_byte1,
    input  logic [7:0] i_out_byte2,
    input  logic [1:0] i_out_part,
    input  logic       i_pair_commit,
    input  logic       i_parse_end,
    input  logic       i_pair_dropped,
    output int         o_failures,
    output int         o_pending,
    output int         o_live_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    import jsonp_pkg::*;

    logic [3:0]  scan_phase;
    logic        in_value;
    logic [15:0] code_point;
    logic [1:0]  hex_seen;
    logic        pair_open;
    t_result     results_q[$];

    function automatic logic is_blank(input logic [7:0] b);
        return b == " " || b == "\t" || b == "\n" || b == "\r";
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    // Advances the parser state by one text byte and returns the result beat it causes.
    function automatic t_result decode_beat(input logic [7:0] b, input logic last);
        t_result     r;
        int          h;
        logic [15:0] cp;
        r = '0;
        case (scan_phase)
            PH_OPEN: begin
                if (!is_blank(b)) begin
                    if (b == "{") scan_phase = PH_AFTER_OPEN;
                    else r.stop = 1'b1;
                end
            end
            PH_AFTER_OPEN, PH_EXPECT_KEY: begin
                if (!is_blank(b)) begin
                    if (b == "\"") begin
                        scan_phase = PH_STR;
                        in_value   = 1'b0;
                        pair_open  = 1'b1;
                    end else begin
                        r.stop = 1'b1;
                    end
                end
            end
            PH_STR: begin
                if (b == "\"") begin
                    if (in_value) begin
                        r.commit   = 1'b1;
                        pair_open  = 1'b0;
                        scan_phase = PH_AFTER_VAL;
                    end else begin
                        scan_phase = PH_AFTER_KEY;
                    end
                end else if (b == "\\") begin
                    scan_phase = PH_ESC;
                end else begin
                    r.count = 2'd1;
                    r.byte0 = b;
                end
            end
            PH_ESC: begin
                scan_phase = PH_STR;
                r.count    = 2'd1;
                case (b)
                    "\"", "\\", "/": r.byte0 = b;
                    "b": r.byte0 = 8'h08;
                    "f": r.byte0 = 8'h0C;
                    "n": r.byte0 = 8'h0A;
                    "r": r.byte0 = 8'h0D;
                    "t": r.byte0 = 8'h09;
                    "u": begin
                        r.count    = 2'd0;
                        scan_phase = PH_HEX;
                        code_point = '0;
                        hex_seen   = '0;
                    end
                    default: begin
                        r.count = 2'd0;
                        r.stop  = 1'b1;
                    end
                endcase
            end
            PH_HEX: begin
                h = hex_nibble(b);
                if (h < 0) begin
                    r.stop = 1'b1;
                end else begin
                    cp         = {code_point[11:0], 4'(h)};
                    code_point = cp;
                    if (hex_seen != 2'd3) begin
                        hex_seen = hex_seen + 2'd1;
                    end else begin
                        if (cp < UTF8_ONE_MAX) begin
                            r.count = 2'd1;
                            r.byte0 = cp[7:0];
                        end else if (cp < UTF8_TWO_MAX) begin
                            r.count = 2'd2;
                            r.byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
                            r.byte1 = UTF8_CONT | (cp[7:0] & UTF8_MASK);
                        end else begin
                            r.count = 2'd3;
                            r.byte0 = UTF8_LEAD3 | {4'h0, cp[15:12]};
                            r.byte1 = UTF8_CONT | {2'b00, cp[11:6]};
                            r.byte2 = UTF8_CONT | (cp[7:0] & UTF8_MASK);
                        end
                        hex_seen   = '0;
                        code_point = '0;
                        scan_phase = PH_STR;
                    end
                end
            end
            PH_AFTER_KEY: begin
                if (!is_blank(b)) begin
                    if (b == ":") scan_phase = PH_BEFORE_VAL;
                    else r.stop = 1'b1;
                end
            end
            PH_BEFORE_VAL: begin
                if (!is_blank(b)) begin
                    if (b == "\"") begin
                        scan_phase = PH_STR;
                        in_value   = 1'b1;
                    end else begin
                        r.stop = 1'b1;
                    end
                end
            end
            PH_AFTER_VAL: begin
                if (!is_blank(b)) begin
                    if (b == ",") scan_phase = PH_EXPECT_KEY;
                    else r.stop = 1'b1;
                end
            end
            default: begin
                // Stopped: bytes are swallowed until the text's last byte has gone by.
                if (last) scan_phase = PH_OPEN;
                return '0;
            end
        endcase
        r.part = (r.count != 2'd0) ? (in_value ? PART_VALUE : PART_KEY) : PART_NONE;
        if (last) r.stop = 1'b1;
        if (r.stop) begin
            r.dropped  = pair_open;
            pair_open  = 1'b0;
            in_value   = 1'b0;
            code_point = '0;
            hex_seen   = '0;
            scan_phase = last ? PH_OPEN : PH_DONE;
        end
        return r;
    endfunction

    function automatic int field_err(input string field_name, input int want, input int got);
        if (want == got) return 0;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field_name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            scan_phase = PH_OPEN;
            in_value   = 1'b0;
            code_point = '0;
            hex_seen   = '0;
            pair_open  = 1'b0;
            results_q.delete();
            o_failures   <= 0;
            o_pending    <= 0;
            o_live_beats <= 0;
        end else begin
            // The result side is handled first: a beat never leaves on the edge it enters.
            if (i_out_valid && i_out_ready) begin
                if (results_q.size() == 0) begin
                    $display("%0t: result beat with none expected, count %0h part %0h",
                             $time, i_out_count, i_out_part);
                    errs = 1;
                end else begin
                    want = results_q.pop_front();
                    errs += field_err("count", want.count, i_out_count);
                    errs += field_err("byte0", want.byte0, i_out_byte0);
                    errs += field_err("byte1", want.byte1, i_out_byte1);
                    errs += field_err("byte2", want.byte2, i_out_byte2);
                    errs += field_err("part", want.part, i_out_part);
                    errs += field_err("pair_commit", want.commit, i_pair_commit);
                    errs += field_err("parse_end", want.stop, i_parse_end);
                    errs += field_err("pair_dropped", want.dropped, i_pair_dropped);
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_live_beats <= o_live_beats + 1;
                results_q = {results_q, decode_beat(i_in_byte, i_in_last)};
            end
            o_failures <= o_failures + errs;
            o_pending  <= results_q.size();
        end
    end

endmodule

[bench/json_flat_object_string_parser_core_tb.sv]
// Testbench top for the flat JSON object parser: clock, reset, text stimulus and verdict.
module json_flat_object_string_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 750;
    localparam int LONG_STALL   = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_out_count;
    logic [7:0] o_out_byte0;
    logic [7:0] o_out_byte1;
    logic [7:0] o_out_byte2;
    logic [1:0] o_out_part;
    logic       o_pair_commit;
    logic       o_parse_end;
    logic       o_pair_dropped;

    int failures;
    int pending;
    int live_beats;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_requests = 0;
    int cycles         = 0;

    logic [7:0] text_q[$];
    string      blanks  = " \t\n\r";
    string      escapes = "\"\\/bfnrt";

    json_flat_object_string_parser_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_count    (o_out_count),
        .o_out_byte0    (o_out_byte0),
        .o_out_byte1    (o_out_byte1),
        .o_out_byte2    (o_out_byte2),
        .o_out_part     (o_out_part),
        .o_pair_commit  (o_pair_commit),
        .o_parse_end    (o_parse_end),
        .o_pair_dropped (o_pair_dropped)
    );

    json_flat_object_string_parser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_out_count    (o_out_count),
        .i_out_byte0    (o_out_byte0),
        .i_out_byte1    (o_out_byte1),
        .i_out_byte2    (o_out_byte2),
        .i_out_part     (o_out_part),
        .i_pair_commit  (o_pair_commit),
        .i_parse_end    (o_parse_end),
        .i_pair_dropped (o_pair_dropped),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_live_beats   (live_beats)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int stalls_served;
        stalls_served = 0;
        forever begin
            @(posedge i_clk);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(2)) add_byte(blanks[$urandom_range(3)]);
    endtask

    task automatic add_string(input int max_len);
        int          sel;
        logic [7:0]  b;
        logic [15:0] cp;
        logic [3:0]  nib;
        add_byte("\"");
        repeat ($urandom_range(max_len)) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                do b = 8'($urandom_range(126, 32)); while (b == "\"" || b == "\\");
                add_byte(b);
            end else if (sel < 55) begin
                do b = 8'($urandom_range(255)); while (b == "\"" || b == "\\");
                add_byte(b);
            end else if (sel < 75) begin
                add_byte("\\");
                add_byte(escapes[$urandom_range(7)]);
            end else if (sel < 97) begin
                case ($urandom_range(3))
                    0: cp = 16'($urandom_range(16'h007F));
                    1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                    2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                    default: begin
                        case ($urandom_range(5))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            default: cp = 16'hFFFF;
                        endcase
                    end
                endcase
                add_str("\\u");
                for (int i = 3; i >= 0; i--) begin
                    nib = cp[i*4 +: 4];
                    if (nib < 4'd10) add_byte("0" + nib);
                    else add_byte(8'(($urandom_range(1) ? "a" : "A") + nib - 10));
                end
            end else begin
                // A likely broken escape: an arbitrary byte, or g or an arbitrary byte after \u0.
                add_byte("\\");
                if ($urandom_range(1)) begin
                    add_byte(8'($urandom_range(255)));
                end else begin
                    add_str("u0");
                    add_byte(8'($urandom_range(1) ? "g" : $urandom_range(255)));
                end
            end
        end
        add_byte("\"");
    endtask

    // Mostly well-formed objects with random content; the rest is cut short,
    // hit by one random byte, or plain noise.
    task automatic build_text();
        int kind;
        int cut;
        kind = $urandom_range(99);
        if (kind < 5) begin
            repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
            return;
        end
        add_blanks();
        add_byte("{");
        add_blanks();
        for (int p = $urandom_range(3); p > 0; p--) begin
            add_string(3);
            add_blanks();
            add_byte(":");
            add_blanks();
            add_string(6);
            add_blanks();
            if (p > 1) begin
                add_byte(",");
                add_blanks();
            end
        end
        add_byte("}");
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
        end
        if (kind >= 90) begin
            cut = $urandom_range(text_q.size() - 1);
            while (text_q.size() > cut + 1) void'(text_q.pop_back());
        end else if (kind >= 80) begin
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text();
        logic [7:0] b;
        while (text_q.size() > 0) begin
            b = text_q.pop_front();
            send_byte(b, text_q.size() == 0);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int target;
        int texts;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty object, closed on the last byte.
        add_str("{}");
        send_text();
        // Extreme raw bytes in a key, an escaped backslash value, then a byte after the close.
        add_str("{\"");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_str("\":\"\\\\\"}x");
        send_text();
        // Closing brace right after a comma is malformed.
        add_str("{\"a\":\"b\",}");
        send_text();
        // Text ends inside a key: the open pair is dropped.
        add_str("{\"a");
        send_text();
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            target = live_beats + RANDOM_BEATS / 4;
            texts  = 0;
            while (live_beats < target) begin
                texts++;
                if (texts == 2 && (ph == 0 || ph == 3)) stall_requests <= stall_requests + 1;
                build_text();
                send_text();
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
